[sv/iqpde_pkg.sv]
// Shared types, constants and tables for the IQ power / dBm estimator.
// Used by iqpde_ctrl, iqpde_datapath and iq_power_dbm_estimator.
// Depends on nothing else.
package iqpde_pkg;

   // Default parameter values for the top level.
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int ACC_BITS_DEF    = 40;

   // Fixed field widths.
   localparam int FIELD_BITS      = 16;
   localparam int LEVEL_BITS      = 13;
   localparam int ALPHA_BITS      = 16;
   localparam int INTERVAL_BITS   = 16;
   localparam int SPAN_BITS       = 7;
   localparam int FLOOR_BITS      = 16;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 16;

   // Stream word widths.
   localparam int REQ_TDATA_BITS  = 2 * FIELD_BITS;
   localparam int RSP_FIELD_BITS  = 2 * FIELD_BITS + 2 * LEVEL_BITS;
   localparam int RSP_TDATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS    = RSP_TDATA_BITS - RSP_FIELD_BITS;

   // Width of one slice of the IIR difference fed to the multiplier.
   localparam int MAC_CHUNK       = 28;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA        = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAG_INTERVAL = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAG_SPAN     = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POWER_FLOOR  = 8'd3;

   // Register reset values.
   localparam logic [ALPHA_BITS-1:0]    ALPHA_RST        = 16'd655;
   localparam logic [INTERVAL_BITS-1:0] TAG_INTERVAL_RST = 16'd1000;
   localparam logic [SPAN_BITS-1:0]     TAG_SPAN_RST     = 7'd4;
   localparam logic [FLOOR_BITS-1:0]    POWER_FLOOR_RST  = 16'd1;

   // Level scaling: 16 * 10 * log10(2) in Q16, the +10 dB term in 1/16 dB,
   // the output clamp and the tag hysteresis of 0.5 dB.
   localparam logic [21:0] LOG_SCALE = 22'd3156542;
   localparam int          LVL_OFFSET = 160;
   localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = -13'sd2784;
   localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = 13'sd256;
   localparam logic signed [LEVEL_BITS:0]   TAG_HYST = 14'sd8;

   // round(256 * log2(1 + k/64)) for the six bits below the leading one.
   localparam logic [7:0] LOG_TAB [64] = '{
      8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
      8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
      8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
      8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
      8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
      8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
      8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
      8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
   };

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_SQ_I,
      OP_SQ_Q,
      OP_DIFF,
      OP_MAC,
      OP_UPDATE,
      OP_NORM,
      OP_LOG,
      OP_LEVEL,
      OP_TAG
   } op_type;

   typedef struct packed {
      op_type op;
      logic   first;    // first slice of a multiply-accumulate run
   } cmd_type;

   typedef struct packed {
      logic at_floor;   // smoothed power is at or below the floor
      logic norm_done;  // leading one has reached the top bit
   } status_type;

endpackage

[sv/iqpde_datapath.sv]
// Datapath of the IQ power / dBm estimator: configuration registers, power,
// IIR average, leading-one search, log conversion, tag state and result word.
// Depends on iqpde_pkg; driven by commands from iqpde_ctrl.
module iqpde_datapath #(
   parameter int SAMPLE_BITS = iqpde_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_BITS    = iqpde_pkg::ACC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  iqpde_pkg::cmd_type                      cmd,
   output iqpde_pkg::status_type                   status,
   input  logic                                    csr_valid,
   input  logic [iqpde_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [iqpde_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic [iqpde_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic [iqpde_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   output logic [0:0]                              rsp_tuser
);

   localparam int FB    = iqpde_pkg::FIELD_BITS;
   localparam int LB    = iqpde_pkg::LEVEL_BITS;
   localparam int AB    = iqpde_pkg::ALPHA_BITS;
   localparam int CH    = iqpde_pkg::MAC_CHUNK;
   localparam int RW    = (SAMPLE_BITS > FB) ? SAMPLE_BITS : FB;
   localparam int SQW   = 2 * SAMPLE_BITS;
   localparam int SCALE = ACC_BITS - SQW;
   localparam int SHL   = (SCALE > 0) ? SCALE : 0;
   localparam int SHR   = (SCALE < 0) ? -SCALE : 0;
   localparam int XW    = ACC_BITS + SQW;
   localparam int NCH   = (ACC_BITS + CH - 1) / CH;
   localparam int MAGW  = NCH * CH;
   localparam int PW    = MAGW + AB;
   localparam int MA    = (SAMPLE_BITS > CH) ? SAMPLE_BITS : CH;
   localparam int MB    = (SAMPLE_BITS > AB) ? SAMPLE_BITS : AB;
   localparam int MPW   = MA + MB;
   localparam int POS_W = $clog2(ACC_BITS);
   localparam int SH0   = 2 ** (POS_W - 1);
   localparam int DW    = $clog2(256 * ACC_BITS) + 1;
   localparam int LW    = MPW + 2;

   // Configuration registers.
   logic [AB-1:0]                          alpha_ff;
   logic [iqpde_pkg::INTERVAL_BITS-1:0]    interval_ff;
   logic [iqpde_pkg::SPAN_BITS-1:0]        span_ff;
   logic [iqpde_pkg::FLOOR_BITS-1:0]       floor_ff;

   // Working registers for one sample.
   logic [FB-1:0]          i_raw_ff, q_raw_ff;
   logic [SAMPLE_BITS-1:0] ai_ff, aq_ff, ai_in, aq_in;
   logic [SQW-1:0]         sq_i_ff, sq_q_ff;
   logic                   dif_neg_ff, dif_neg_in;
   logic [MAGW-1:0]        mag_ff, mag_in;
   logic [PW-1:0]          acc_ff, acc_in;
   logic [ACC_BITS-1:0]    avg_ff, avg_in;
   logic [ACC_BITS-1:0]    norm_ff, norm_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       sh_ff;
   logic [MPW-1:0]         logp_ff;
   logic                   log_neg_ff;
   logic signed [LB-1:0]   level_ff, level_in;

   // Tag state.
   logic [iqpde_pkg::INTERVAL_BITS-1:0] count_ff, count_in;
   logic signed [LB-1:0]                last_tag_ff, last_tag_in;
   logic [iqpde_pkg::SPAN_BITS-1:0]     remain_ff, remain_in;
   logic signed [LB-1:0]                run_tag_ff, run_tag_in;

   // Result word.
   logic [FB-1:0]        i_out_ff, q_out_ff;
   logic signed [LB-1:0] level_out_ff, tag_level_ff, tag_level_in;
   logic                 tag_valid_ff, tag_valid_in;

   // Shared multiplier.
   logic [MA-1:0]  mul_a;
   logic [MB-1:0]  mul_b;
   logic [MPW-1:0] mul_p;

   // Combinational helpers.
   logic [RW-1:0]          i_ext, q_ext;
   logic [SAMPLE_BITS-1:0] i_v, q_v;
   logic [SQW-1:0]         psum;
   logic [XW-1:0]          xw;
   logic [ACC_BITS-1:0]    x_val;
   logic [PW-1:0]          acc_rnd;
   logic [ACC_BITS-1:0]    step_q;
   logic [POS_W:0]         top_shamt;
   logic                   top_zero;
   logic [5:0]             frac_k;
   logic [DW-1:0]          d_val, d_mag;
   logic signed [LW-1:0]   p_sgn, p_rnd, p_lvl;
   logic                   raise;
   logic signed [LB:0]     t_diff, t_abs;
   logic                   at_floor;

   // Magnitude of a sample taken from the low SAMPLE_BITS bits of a field.
   always_comb begin
      i_ext = RW'(req_tdata[FB-1:0]);
      q_ext = RW'(req_tdata[2*FB-1:FB]);
      i_v   = i_ext[SAMPLE_BITS-1:0];
      q_v   = q_ext[SAMPLE_BITS-1:0];
      ai_in = i_v[SAMPLE_BITS-1] ? (~i_v + 1'b1) : i_v;
      aq_in = q_v[SAMPLE_BITS-1] ? (~q_v + 1'b1) : q_v;
   end

   // Operand selection for the one multiplier.
   always_comb begin
      frac_k = norm_ff[ACC_BITS-2 -: 6];
      d_val  = DW'({pos_ff, 8'h00}) + DW'(iqpde_pkg::LOG_TAB[frac_k])
             - DW'(256 * (ACC_BITS - 2));
      d_mag  = d_val[DW-1] ? (~d_val + 1'b1) : d_val;
      unique case (cmd.op)
         iqpde_pkg::OP_SQ_I: begin
            mul_a = MA'(ai_ff);
            mul_b = MB'(ai_ff);
         end
         iqpde_pkg::OP_SQ_Q: begin
            mul_a = MA'(aq_ff);
            mul_b = MB'(aq_ff);
         end
         iqpde_pkg::OP_MAC: begin
            mul_a = MA'(mag_ff[MAGW-1 -: CH]);
            mul_b = MB'(alpha_ff);
         end
         iqpde_pkg::OP_LOG: begin
            mul_a = MA'(iqpde_pkg::LOG_SCALE);
            mul_b = MB'(d_mag);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = MPW'(mul_a) * MPW'(mul_b);
   end

   // Power, IIR difference and update, leading-one step.
   always_comb begin
      psum       = sq_i_ff + sq_q_ff;
      xw         = (XW'(psum) << SHL) >> SHR;
      x_val      = xw[ACC_BITS-1:0];
      dif_neg_in = x_val < avg_ff;
      mag_in     = dif_neg_in ? MAGW'(avg_ff - x_val) : MAGW'(x_val - avg_ff);
      if (cmd.op == iqpde_pkg::OP_MAC) begin
         mag_in = mag_ff << CH;
      end
      acc_in  = (cmd.first ? '0 : (acc_ff << CH)) + PW'(mul_p);
      // The old average plus floor(alpha * (x - avg) / 65536).
      acc_rnd = dif_neg_ff ? (acc_ff + PW'({AB{1'b1}})) : acc_ff;
      step_q  = ACC_BITS'(acc_rnd >> AB);
      avg_in  = dif_neg_ff ? (avg_ff - step_q) : (avg_ff + step_q);

      top_shamt = (POS_W + 1)'(ACC_BITS) - (POS_W + 1)'(sh_ff);
      top_zero  = (norm_ff >> top_shamt) == '0;
      norm_in   = top_zero ? (norm_ff << sh_ff) : norm_ff;
      pos_in    = top_zero ? (pos_ff - sh_ff) : pos_ff;
   end

   assign at_floor = (avg_ff <= ACC_BITS'(floor_ff)) || (avg_ff == '0);
   assign status.at_floor  = at_floor;
   assign status.norm_done = norm_ff[ACC_BITS-1];

   // Round the scaled log, add the +10 dB term and clamp; a power at the floor gives the bottom level.
   always_comb begin
      p_sgn = log_neg_ff ? -$signed(LW'(logp_ff)) : $signed(LW'(logp_ff));
      p_rnd = p_sgn + $signed(LW'(1 << 23));
      p_lvl = (p_rnd >>> 24) + $signed(LW'(iqpde_pkg::LVL_OFFSET));
      if (at_floor) begin
         level_in = iqpde_pkg::LVL_MIN;
      end else if (p_lvl < $signed(LW'(iqpde_pkg::LVL_MIN))) begin
         level_in = iqpde_pkg::LVL_MIN;
      end else if (p_lvl > $signed(LW'(iqpde_pkg::LVL_MAX))) begin
         level_in = iqpde_pkg::LVL_MAX;
      end else begin
         level_in = LB'(p_lvl);
      end
   end

   // Tag decision on the finished level.
   always_comb begin
      t_diff = (LB + 1)'(last_tag_ff) - (LB + 1)'(level_ff);
      t_abs  = t_diff[LB] ? -t_diff : t_diff;
      raise  = (count_ff >= interval_ff) && (t_abs > iqpde_pkg::TAG_HYST);
      if (raise) begin
         count_in = 16'd1;
      end else if (count_ff >= interval_ff) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + 1'b1;
      end
      last_tag_in  = raise ? level_ff : last_tag_ff;
      run_tag_in   = raise ? level_ff : run_tag_ff;
      remain_in    = raise ? span_ff : remain_ff;
      tag_valid_in = remain_in != '0;
      tag_level_in = tag_valid_in ? run_tag_in : '0;
      if (tag_valid_in) begin
         remain_in = remain_in - 1'b1;
      end
   end

   // State that reset defines.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= iqpde_pkg::ALPHA_RST;
         interval_ff <= iqpde_pkg::TAG_INTERVAL_RST;
         span_ff     <= iqpde_pkg::TAG_SPAN_RST;
         floor_ff    <= iqpde_pkg::POWER_FLOOR_RST;
         avg_ff      <= '0;
         count_ff    <= 16'd1;
         last_tag_ff <= '0;
         remain_ff   <= '0;
         run_tag_ff  <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               iqpde_pkg::CSR_ALPHA:        alpha_ff    <= csr_data;
               iqpde_pkg::CSR_TAG_INTERVAL: interval_ff <= csr_data;
               iqpde_pkg::CSR_TAG_SPAN:     span_ff     <= csr_data[iqpde_pkg::SPAN_BITS-1:0];
               iqpde_pkg::CSR_POWER_FLOOR:  floor_ff    <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == iqpde_pkg::OP_UPDATE) begin
            avg_ff <= avg_in;
         end
         if (cmd.op == iqpde_pkg::OP_TAG) begin
            count_ff    <= count_in;
            last_tag_ff <= last_tag_in;
            remain_ff   <= remain_in;
            run_tag_ff  <= run_tag_in;
         end
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         iqpde_pkg::OP_LOAD: begin
            i_raw_ff <= req_tdata[FB-1:0];
            q_raw_ff <= req_tdata[2*FB-1:FB];
            ai_ff    <= ai_in;
            aq_ff    <= aq_in;
         end
         iqpde_pkg::OP_SQ_I: sq_i_ff <= SQW'(mul_p);
         iqpde_pkg::OP_SQ_Q: sq_q_ff <= SQW'(mul_p);
         iqpde_pkg::OP_DIFF: begin
            dif_neg_ff <= dif_neg_in;
            mag_ff     <= mag_in;
         end
         iqpde_pkg::OP_MAC: begin
            mag_ff <= mag_in;
            acc_ff <= acc_in;
         end
         iqpde_pkg::OP_UPDATE: begin
            norm_ff <= avg_in;
            pos_ff  <= POS_W'(ACC_BITS - 1);
            sh_ff   <= POS_W'(SH0);
         end
         iqpde_pkg::OP_NORM: begin
            norm_ff <= norm_in;
            pos_ff  <= pos_in;
            sh_ff   <= sh_ff >> 1;
         end
         iqpde_pkg::OP_LOG: begin
            logp_ff    <= mul_p;
            log_neg_ff <= d_val[DW-1];
         end
         iqpde_pkg::OP_LEVEL: level_ff <= level_in;
         iqpde_pkg::OP_TAG: begin
            i_out_ff     <= i_raw_ff;
            q_out_ff     <= q_raw_ff;
            level_out_ff <= level_ff;
            tag_valid_ff <= tag_valid_in;
            tag_level_ff <= tag_level_in;
         end
         default: ;
      endcase
   end

   assign rsp_tdata = {{iqpde_pkg::RSP_PAD_BITS{1'b0}}, tag_level_ff, level_out_ff,
                       q_out_ff, i_out_ff};
   assign rsp_tuser = tag_valid_ff;

   // The log step must only ever see a normalized word.
   a_norm_before_log: assert property (@(posedge clock) disable iff (reset)
      cmd.op == iqpde_pkg::OP_LOG |-> norm_ff[ACC_BITS-1])
      else $error("log conversion started on a word that is not normalized");

   // A power at the floor always yields the bottom level.
   a_floor_level: assert property (@(posedge clock) disable iff (reset)
      cmd.op == iqpde_pkg::OP_LEVEL && at_floor |=> level_ff == iqpde_pkg::LVL_MIN)
      else $error("floor power did not give the bottom level");

endmodule

[sv/iqpde_ctrl.sv]
// Controller of the IQ power / dBm estimator: sequences one sample through
// the datapath and owns the input and output handshakes.
// Depends on iqpde_pkg; drives iqpde_datapath through cmd_type.
module iqpde_ctrl #(
   parameter int ACC_BITS = iqpde_pkg::ACC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output iqpde_pkg::cmd_type    cmd,
   input  iqpde_pkg::status_type status
);

   localparam int NCH   = (ACC_BITS + iqpde_pkg::MAC_CHUNK - 1) / iqpde_pkg::MAC_CHUNK;
   localparam int NSTEP = $clog2(ACC_BITS);
   localparam int NMAX  = (NSTEP > NCH) ? NSTEP : NCH;
   localparam int CNT_W = $clog2(NMAX);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_I,
      S_SQ_Q,
      S_DIFF,
      S_MAC,
      S_UPDATE,
      S_NORM,
      S_LOG,
      S_LEVEL,
      S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = iqpde_pkg::OP_NOP;
      cmd.first    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = iqpde_pkg::OP_LOAD;
               state_in = S_SQ_I;
            end
         end
         S_SQ_I: begin
            cmd.op   = iqpde_pkg::OP_SQ_I;
            state_in = S_SQ_Q;
         end
         S_SQ_Q: begin
            cmd.op   = iqpde_pkg::OP_SQ_Q;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = iqpde_pkg::OP_DIFF;
            cnt_in   = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            cmd.op    = iqpde_pkg::OP_MAC;
            cmd.first = cnt_ff == '0;
            if (cnt_ff == CNT_W'(NCH - 1)) begin
               cnt_in   = '0;
               state_in = S_UPDATE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_UPDATE: begin
            cmd.op   = iqpde_pkg::OP_UPDATE;
            cnt_in   = '0;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (status.at_floor) begin
               state_in = S_LEVEL;
            end else if (status.norm_done) begin
               state_in = S_LOG;
            end else begin
               cmd.op = iqpde_pkg::OP_NORM;
               if (cnt_ff == CNT_W'(NSTEP - 1)) begin
                  state_in = S_LOG;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_LOG: begin
            cmd.op   = iqpde_pkg::OP_LOG;
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            cmd.op   = iqpde_pkg::OP_LEVEL;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = iqpde_pkg::OP_TAG;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   // Only one sample is in flight.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("a second word was taken while one was in flight");

   // A result is only written into a free or draining output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == iqpde_pkg::OP_TAG |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten before it was taken");

   // The slice counter stays inside the accumulate run.
   a_mac_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MAC |-> cnt_ff <= CNT_W'(NCH - 1))
      else $error("multiply-accumulate slice count out of range");

endmodule

[sv/iq_power_dbm_estimator.sv]
// Top level of the IQ power / dBm estimator (received signal strength with
// level tags). Instantiates iqpde_ctrl and iqpde_datapath; uses iqpde_pkg.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   req_tdata: i_sample, q_sample
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata: i_out, q_out,
//                                               level_dbm, tag_level;
//                                               rsp_tuser: tag_valid
//   csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// One sample is in flight at a time. The IIR multiply-accumulate runs in NCH =
// ceil(ACC_BITS/28) slices, and the leading-one search sets the variable part of the
// sequence. A power at or below the floor skips the search and the log step.
// Reset is synchronous and active high and restores the defaults.
// The result sits in an output register; a stalled rsp side delays only the next write.
module iq_power_dbm_estimator #(
   parameter int SAMPLE_BITS = iqpde_pkg::SAMPLE_BITS_DEF,
   parameter int ACC_BITS    = iqpde_pkg::ACC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: i_sample[15:0], q_sample[31:16].
   input  logic [iqpde_pkg::REQ_TDATA_BITS-1:0]  req_tdata,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0 up: i_out[15:0], q_out[31:16], level_dbm[44:32],
   // tag_level[57:45], zeros[63:58].
   output logic [iqpde_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata,
   // Fields from bit 0 up: tag_valid[0].
   output logic [0:0]                            rsp_tuser,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [iqpde_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [iqpde_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   iqpde_pkg::cmd_type    cmd;
   iqpde_pkg::status_type status;

   // Register writes are taken in every cycle. Indexes that name no
   // register are accepted and dropped.
   assign csr_ready = 1'b1;

   // The controller walks each sample through squaring, the sliced IIR
   // update, normalization, the log step, rounding and the tag decision.
   iqpde_ctrl #(
      .ACC_BITS (ACC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds every register of the block but the controller's state,
   // including the configuration registers and the result word.
   iqpde_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

[tb/tb_iq_power_dbm_estimator.sv]
// Self-checking testbench for iq_power_dbm_estimator: IQ samples in, passthrough
// plus smoothed dBm level and level tags out, checked against an in-bench predictor.
// Depends on iqpde_pkg and the iq_power_dbm_estimator RTL.
`timescale 1ns / 1ps

module tb_iq_power_dbm_estimator;

   // Level arithmetic, all in 1/16 dB. The scale is 16 * 10 * log10(2) in Q16.
   localparam int      LEVEL_LOW          = -2784;
   localparam int      LEVEL_HIGH         = 256;
   localparam longint  DB16_PER_OCTAVE_Q16 = 3156542;
   localparam int      PLUS_TEN_DB        = 160;
   localparam int      RAISE_OFFSET       = 4096;
   localparam int      ACC_WIDTH          = 40;
   localparam int      POWER_SHIFT        = ACC_WIDTH - 32;
   localparam int      HYSTERESIS_STEPS   = 8;
   localparam int      CYCLE_LIMIT        = 400000;
   localparam int      RANDOM_PHASES      = 12;
   localparam int      PHASE_SAMPLES      = 170;
   localparam int      TRAIL_CYCLES       = 40;
   localparam logic [iqpde_pkg::CSR_INDEX_BITS-1:0] FIRST_UNUSED_INDEX =
      iqpde_pkg::CSR_INDEX_BITS'(iqpde_pkg::CSR_POWER_FLOOR + 1);

   // Fractional part of log2 in 1/256 steps, indexed by the six bits below
   // the leading one of the smoothed power.
   localparam int LOG2_FRAC [64] = '{
      0, 6, 11, 17, 22, 28, 33, 38, 44, 49, 54, 59, 63, 68, 73, 78,
      82, 87, 92, 96, 100, 105, 109, 113, 118, 122, 126, 130, 134, 138, 142, 146,
      150, 154, 157, 161, 165, 169, 172, 176, 179, 183, 186, 190, 193, 197, 200, 203,
      207, 210, 213, 216, 220, 223, 226, 229, 232, 235, 238, 241, 244, 247, 250, 253
   };

   typedef struct {
      logic signed [15:0] i;
      logic signed [15:0] q;
   } iq_word_type;

   typedef struct {
      logic signed [15:0] i;
      logic signed [15:0] q;
      logic signed [12:0] level;
      logic               has_tag;
      logic signed [12:0] tag_level;
   } level_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // Fields from bit 0 up: i_sample[15:0], q_sample[31:16].
   logic [iqpde_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;

   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // Fields from bit 0 up: i_out[15:0], q_out[31:16], level_dbm[44:32],
   // tag_level[57:45], zeros[63:58].
   logic [iqpde_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   // Fields from bit 0 up: tag_valid[0].
   logic [0:0]                           rsp_tuser;

   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [iqpde_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [iqpde_pkg::CSR_DATA_BITS-1:0]  csr_data = '0;

   iq_power_dbm_estimator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor copy of the registers, at their reset values.
   logic [15:0] cfg_alpha    = 16'd655;
   logic [15:0] cfg_interval = 16'd1000;
   logic [6:0]  cfg_span     = 7'd4;
   logic [15:0] cfg_floor    = 16'd1;

   // Predictor copy of the estimator state, at its reset values.
   logic [ACC_WIDTH-1:0] smoothed_power    = '0;
   logic [15:0]          samples_since_tag = 16'd1;
   int                   last_tag_level    = 0;
   int                   tag_left          = 0;
   int                   live_tag_level    = 0;

   iq_word_type    sample_queue[$];
   level_word_type expected_words[$];

   // Handshake flags raised at the rising edge and used by the falling-edge drivers.
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_calm  = 1'b0;
   bit rsp_calm  = 1'b0;
   int req_wait  = 0;
   int rsp_stall = 0;

   int cycle_count   = 0;
   int error_count   = 0;
   int words_checked = 0;
   int tags_seen     = 0;
   int floor_seen    = 0;
   int setting_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Instantaneous power I*I + Q*Q, scaled up into the accumulator format.
   function automatic logic [ACC_WIDTH-1:0] inst_power(iq_word_type s);
      longint mi;
      longint mq;
      mi = s.i;
      mq = s.q;
      if (mi < 0) mi = -mi;
      if (mq < 0) mq = -mq;
      return ACC_WIDTH'((mi * mi + mq * mq) << POWER_SHIFT);
   endfunction

   // Smoothed power to dBm in 1/16 dB: leading one plus a six-bit mantissa
   // gives log2 in 1/256 steps, which is rescaled with rounding and clamped.
   function automatic int level_of_power(logic [ACC_WIDTH-1:0] p);
      int     lead;
      int     mant;
      longint acc;
      longint lvl;
      if (p <= cfg_floor || p == 0) return LEVEL_LOW;
      lead = ACC_WIDTH - 1;
      while (lead > 0 && !p[lead]) lead--;
      if (lead >= 6) mant = int'((p >> (lead - 6)) & 63);
      else mant = int'((p << (6 - lead)) & 63);
      acc = (longint'(256 * lead + LOG2_FRAC[mant]) - longint'(256 * (ACC_WIDTH - 2)))
            * DB16_PER_OCTAVE_Q16
            + (longint'(PLUS_TEN_DB + RAISE_OFFSET) << 24) + (longint'(1) << 23);
      if (acc < 0) acc = 0;
      lvl = (acc >> 24) - RAISE_OFFSET;
      if (lvl < LEVEL_LOW) lvl = LEVEL_LOW;
      if (lvl > LEVEL_HIGH) lvl = LEVEL_HIGH;
      return int'(lvl);
   endfunction

   // Advance the predicted state by one accepted sample and queue its result.
   task automatic predict_level_word(iq_word_type s);
      level_word_type w;
      longint unsigned weight;
      longint unsigned mixed;
      int lvl;
      int delta;
      weight = longint'(cfg_alpha);
      // Exact single-pole update, floor of the weighted sum over 2^16.
      mixed = ((65536 - weight) * smoothed_power + weight * inst_power(s)) >> 16;
      smoothed_power = mixed[ACC_WIDTH-1:0];
      lvl = level_of_power(smoothed_power);
      if (samples_since_tag >= cfg_interval) begin
         delta = last_tag_level - lvl;
         if (delta < 0) delta = -delta;
         // A moved level restarts the count and starts a new tag, which
         // replaces any tag still being marked.
         if (delta > HYSTERESIS_STEPS) begin
            samples_since_tag = 16'd1;
            last_tag_level = lvl;
            live_tag_level = lvl;
            tag_left = int'(cfg_span);
         end
      end else begin
         samples_since_tag = samples_since_tag + 16'd1;
      end
      w.i = s.i;
      w.q = s.q;
      w.level = 13'(lvl);
      w.has_tag = 1'b0;
      w.tag_level = '0;
      if (tag_left > 0) begin
         w.has_tag = 1'b1;
         w.tag_level = 13'(live_tag_level);
         tag_left--;
      end
      if (lvl == LEVEL_LOW) floor_seen++;
      if (w.has_tag) tags_seen++;
      expected_words.push_back(w);
   endtask

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Everything observed at the rising edge: results are checked before a new
   // sample is predicted, so a same-edge pair never confuses the order.
   always @(posedge clock) begin
      level_word_type want;
      iq_word_type s;
      cycle_count++;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_taken = 1'b1;
            if (expected_words.size() == 0) begin
               $error("result word with no sample outstanding");
               error_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("i_out", want.i, $signed(rsp_tdata[15:0]));
               check_field("q_out", want.q, $signed(rsp_tdata[31:16]));
               check_field("level_dbm", want.level, $signed(rsp_tdata[44:32]));
               check_field("tag_level", want.tag_level, $signed(rsp_tdata[57:45]));
               check_field("tdata_pad", 0, 32'(rsp_tdata[63:58]));
               check_field("tag_valid", 32'(want.has_tag), 32'(rsp_tuser[0]));
               words_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            s.i = req_tdata[15:0];
            s.q = req_tdata[31:16];
            predict_level_word(s);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               iqpde_pkg::CSR_ALPHA:        cfg_alpha    = csr_data;
               iqpde_pkg::CSR_TAG_INTERVAL: cfg_interval = csr_data;
               iqpde_pkg::CSR_TAG_SPAN:     cfg_span     = csr_data[6:0];
               iqpde_pkg::CSR_POWER_FLOOR:  cfg_floor    = csr_data;
               default: ;   // unused indexes leave every register alone
            endcase
         end
      end
   end

   // Sample driver. A word leaves the bus once taken; the next one follows
   // after the gap drawn for it, and calm stretches run with no gaps at all.
   always @(negedge clock) begin
      logic next_valid;
      logic [iqpde_pkg::REQ_TDATA_BITS-1:0] next_data;
      iq_word_type s;
      next_valid = req_tvalid;
      next_data = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (sample_queue.size() != 0) begin
               s = sample_queue.pop_front();
               next_data = {s.q, s.i};
               next_valid = 1'b1;
               if ($urandom_range(0, 31) == 0) req_calm = !req_calm;
               req_wait = req_calm ? 0 : int'($urandom_range(0, 12));
            end
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
   end

   // Result receiver. After each taken word it draws a stall, counted down
   // only while a result is actually waiting.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 31) == 0) rsp_calm = !rsp_calm;
            rsp_stall = rsp_calm ? 0 : int'($urandom_range(0, 12));
         end
         if (rsp_stall > 0 && rsp_tvalid) rsp_stall--;
         rsp_tready <= (rsp_stall == 0);
      end
   end

   task automatic queue_sample(int i, int q);
      iq_word_type s;
      s.i = i[15:0];
      s.q = q[15:0];
      sample_queue.push_back(s);
   endtask

   // Blocks until nothing is queued, on the bus or waiting for its result.
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [iqpde_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [iqpde_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random phase content: mostly runs of samples at one amplitude class, so
   // the average settles and then jumps, plus some full-range noise words.
   task automatic queue_phase(int count);
      int made;
      int run;
      int shift;
      logic signed [15:0] a;
      logic signed [15:0] b;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_sample(int'($urandom), int'($urandom));
            made++;
         end else begin
            run = int'($urandom_range(1, 30));
            shift = int'($urandom_range(0, 15));
            repeat (run) begin
               a = 16'($urandom);
               b = 16'($urandom);
               queue_sample(int'(a >>> shift), int'(b >>> shift));
            end
            made += run;
         end
      end
   endtask

   // Pick a register setting per phase; the first phases walk the extremes.
   task automatic program_phase(int phase);
      int sel;
      logic [15:0] val;
      sel = (phase < 4) ? phase : int'($urandom_range(0, 5));
      case (sel)
         0: val = 16'd0;
         1: val = 16'hFFFF;
         2: val = 16'd1;
         3: val = 16'($urandom);
         default: val = 16'($urandom_range(8192, 65535));
      endcase
      write_reg(iqpde_pkg::CSR_ALPHA, val);
      sel = (phase < 4) ? phase : int'($urandom_range(0, 5));
      case (sel)
         0: val = 16'd0;
         1: val = 16'hFFFF;
         2: val = 16'd1000;
         default: val = 16'($urandom_range(1, 24));
      endcase
      write_reg(iqpde_pkg::CSR_TAG_INTERVAL, val);
      // Upper data bits are random; only the low seven reach the span.
      sel = (phase < 4) ? phase : int'($urandom_range(0, 5));
      val = 16'($urandom);
      case (sel)
         0: val[6:0] = 7'd0;
         1: val[6:0] = 7'd64;
         2: val[6:0] = 7'd127;
         3: val[6:0] = 7'd1;
         default: val[6:0] = 7'($urandom_range(1, 8));
      endcase
      write_reg(iqpde_pkg::CSR_TAG_SPAN, val);
      sel = (phase < 4) ? phase : int'($urandom_range(0, 5));
      case (sel)
         0: val = 16'd0;
         1: val = 16'hFFFF;
         2: val = 16'd1;
         3: val = 16'($urandom);
         default: val = 16'($urandom_range(0, 4000));
      endcase
      write_reg(iqpde_pkg::CSR_POWER_FLOOR, val);
      if ($urandom_range(0, 2) == 0)
         write_reg(iqpde_pkg::CSR_INDEX_BITS'($urandom_range(FIRST_UNUSED_INDEX, 255)),
                   iqpde_pkg::CSR_DATA_BITS'($urandom));
      setting_count++;
   endtask

   initial begin
      int phase;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: silence, full-scale corners (including the most
      // negative value on both axes) and alternating bit patterns.
      setting_count = 1;
      queue_sample(0, 0);
      queue_sample(-32768, -32768);
      queue_sample(32767, 32767);
      queue_sample(-32768, 32767);
      queue_sample(1, -1);
      queue_sample(16'sh5555, -16'sh5556);
      queue_sample(-1, 0);
      wait_idle();

      // Fast average, tag test on every sample, span above 64 with junk in
      // the upper data bits, zero floor. Alternating levels raise a new tag
      // on each sample, each one replacing the tag still running.
      write_reg(iqpde_pkg::CSR_ALPHA, 16'hFFFF);
      write_reg(iqpde_pkg::CSR_TAG_INTERVAL, 16'd1);
      write_reg(iqpde_pkg::CSR_TAG_SPAN, 16'hFFE4);
      write_reg(iqpde_pkg::CSR_POWER_FLOOR, 16'd0);
      setting_count++;
      repeat (3) begin
         queue_sample(32767, -32768);
         queue_sample(64, 0);
      end
      wait_idle();

      // Zero span: tags are still raised and counted, but nothing is marked.
      write_reg(iqpde_pkg::CSR_TAG_SPAN, 16'd0);
      queue_sample(-32768, 32767);
      queue_sample(0, 100);
      queue_sample(30000, 30000);
      queue_sample(5, 5);
      wait_idle();

      // Zero alpha freezes the average whatever arrives.
      write_reg(iqpde_pkg::CSR_ALPHA, 16'd0);
      write_reg(iqpde_pkg::CSR_TAG_SPAN, 16'd3);
      queue_sample(-32768, -32768);
      queue_sample(0, 0);
      queue_sample(12345, -12345);
      wait_idle();

      // High floor with quiet input pins the level at the bottom; writes to
      // unused indexes must change nothing.
      write_reg(iqpde_pkg::CSR_ALPHA, 16'hFFFF);
      write_reg(iqpde_pkg::CSR_TAG_INTERVAL, 16'd2);
      write_reg(iqpde_pkg::CSR_POWER_FLOOR, 16'hFFFF);
      write_reg(FIRST_UNUSED_INDEX, 16'hFFFF);
      write_reg(8'hFF, 16'h0000);
      setting_count++;
      queue_sample(8, 8);
      queue_sample(0, 0);
      queue_sample(-8, 7);
      queue_sample(1, 0);
      wait_idle();

      // Random phases. Each one drains completely before the registers move,
      // which also makes the sender sit idle until every result is back.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_phase(phase);
         queue_phase(PHASE_SAMPLES);
         wait_idle();
      end

      repeat (TRAIL_CYCLES) @(posedge clock);
      $display("Checked %0d result words over %0d register settings.",
               words_checked, setting_count);
      $display("%0d words carried a level tag and %0d sat at the power floor.",
               tags_seen, floor_seen);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("tb_iq_power_dbm_estimator: clean");
      end else begin
         if (expected_words.size() != 0)
            $error("%0d result words never arrived", expected_words.size());
         $display("tb_iq_power_dbm_estimator: errors");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles.", cycle_count);
      $display("tb_iq_power_dbm_estimator: errors");
      $finish;
   end

endmodule

[sim.f]
sv/iqpde_pkg.sv
sv/iqpde_datapath.sv
sv/iqpde_ctrl.sv
sv/iq_power_dbm_estimator.sv
tb/tb_iq_power_dbm_estimator.sv
